// ----- design/swm_pkg.sv -----
// Shared types and constants for the sliding window median block.
// No dependencies; the files that use it refer to this package by scoped name.
package swm_pkg;

	localparam int CFG_W = 7;

	// Register indexes, taken from paddr[2]
	localparam logic REG_WINDOW_SIZE   = 1'b0;
	localparam logic REG_LEAST_PRESENT = 1'b1;

	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST   = 7'd5;
	localparam logic [CFG_W-1:0] LEAST_PRESENT_RST = 7'd1;

	// tuser bit positions on the input side
	localparam int TUSER_MISSING = 0;
	localparam int TUSER_START   = 1;

	typedef struct packed {
		logic [CFG_W-1:0] window_size;
		logic [CFG_W-1:0] least_present;
		logic             clear;
	} cfg_t;

endpackage

// ----- design/swm_ram.sv -----
// Simple dual-port memory: one write port, one read port with registered data.
// No dependencies.
module swm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/swm_ctrl.sv -----
// Sequencer of the median filter: ring buffer of recent samples, sorted value
// memory walked by one shared comparator, and the median step.
// Depends on swm_pkg and swm_ram.
module swm_ctrl #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swm_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                    in_missing,
	input  logic                    in_start,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [SAMPLE_WIDTH-1:0] res_median,
	output logic                    res_ok
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int EW = (CW > swm_pkg::CFG_W) ? CW : swm_pkg::CFG_W;
	localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [EW-1:0] WMAX_E = EW'(WINDOW_MAX);
	localparam logic [CW:0]   WMAX_S = (CW+1)'(WINDOW_MAX);
	localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_MAX - 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_EVICT   = 4'd1;
	localparam logic [3:0] ST_EVWAIT  = 4'd2;
	localparam logic [3:0] ST_REMOVE  = 4'd3;
	localparam logic [3:0] ST_WRITE   = 4'd4;
	localparam logic [3:0] ST_INSERT  = 4'd5;
	localparam logic [3:0] ST_INSLAST = 4'd6;
	localparam logic [3:0] ST_MEDRD   = 4'd7;
	localparam logic [3:0] ST_MEDLO   = 4'd8;
	localparam logic [3:0] ST_MEDHI   = 4'd9;
	localparam logic [3:0] ST_MEDSUM  = 4'd10;
	localparam logic [3:0] ST_DONE    = 4'd11;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] oldest_q, oldest_d;
	logic [CW-1:0] present_q, present_d;
	logic [AW-1:0] idx_q, idx_d;
	logic          found_q, found_d;

	logic [SAMPLE_WIDTH-1:0] key_q, key_d;
	logic                    miss_q, miss_d;
	logic [SAMPLE_WIDTH-1:0] evkey_q, evkey_d;
	logic [SAMPLE_WIDTH-1:0] lo_q, lo_d;
	logic [SAMPLE_WIDTH-1:0] diff_q, diff_d;
	logic [SAMPLE_WIDTH-1:0] med_q, med_d;
	logic                    ok_q, ok_d;

	logic                    ring_we;
	logic [AW-1:0]           ring_waddr, ring_raddr;
	logic [SAMPLE_WIDTH:0]   ring_wdata, ring_rdata;
	logic                    srt_we;
	logic [AW-1:0]           srt_waddr, srt_raddr;
	logic [SAMPLE_WIDTH-1:0] srt_wdata, srt_rdata;

	logic [EW-1:0] ws_e, w_eff, mc_e, need;
	logic          fill_full, med_ok;
	logic [CW:0]   pos_sum;
	logic [AW-1:0] write_pos, half;
	logic [SAMPLE_WIDTH-1:0] cmp_b;
	logic          cmp_eq, cmp_gt;

	// Ring of recent samples: missing flag on top of the biased value
	swm_ram #(.DEPTH(WINDOW_MAX), .WIDTH(SAMPLE_WIDTH + 1)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Present values in ascending biased order
	swm_ram #(.DEPTH(WINDOW_MAX), .WIDTH(SAMPLE_WIDTH)) u_sorted (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (srt_wdata),
		.raddr (srt_raddr),
		.rdata (srt_rdata)
	);

	assign ws_e      = EW'(cfg.window_size);
	assign w_eff     = (ws_e == '0) ? EW'(1) : ((ws_e > WMAX_E) ? WMAX_E : ws_e);
	assign mc_e      = EW'(cfg.least_present);
	assign need      = (mc_e == '0) ? EW'(1) : mc_e;
	assign fill_full = EW'(fill_q) >= w_eff;
	assign med_ok    = (present_q != '0) && (EW'(present_q) >= need);

	// Oldest plus fill stays below twice the depth: one subtract wraps it
	assign pos_sum   = (CW+1)'(oldest_q) + (CW+1)'(fill_q);
	assign write_pos = (pos_sum >= WMAX_S) ? AW'(pos_sum - WMAX_S) : AW'(pos_sum);
	assign half      = AW'(present_q >> 1);

	// The one comparator, shared by the remove and insert walks
	assign cmp_b  = (state_q == ST_REMOVE) ? evkey_q : key_q;
	assign cmp_eq = srt_rdata == cmp_b;
	assign cmp_gt = srt_rdata > cmp_b;

	assign in_ready   = state_q == ST_IDLE;
	assign res_valid  = state_q == ST_DONE;
	assign res_median = med_q;
	assign res_ok     = ok_q;

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		oldest_d  = oldest_q;
		present_d = present_q;
		idx_d     = idx_q;
		found_d   = found_q;
		key_d     = key_q;
		miss_d    = miss_q;
		evkey_d   = evkey_q;
		lo_d      = lo_q;
		diff_d    = diff_q;
		med_d     = med_q;
		ok_d      = ok_q;
		ring_we    = 1'b0;
		ring_waddr = write_pos;
		ring_wdata = {miss_q, key_q};
		ring_raddr = oldest_q;
		srt_we     = 1'b0;
		srt_waddr  = '0;
		srt_wdata  = key_q;
		srt_raddr  = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					key_d  = in_sample ^ SIGN_BIT;
					miss_d = in_missing;
					if (in_start) begin
						fill_d    = '0;
						oldest_d  = '0;
						present_d = '0;
					end
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				// Read of the oldest ring entry is issued here
				state_d = fill_full ? ST_EVWAIT : ST_WRITE;
			end
			ST_EVWAIT: begin
				oldest_d = (oldest_q == LAST_POS) ? '0 : oldest_q + 1'b1;
				fill_d   = fill_q - 1'b1;
				if (!ring_rdata[SAMPLE_WIDTH]) begin
					evkey_d = ring_rdata[SAMPLE_WIDTH-1:0];
					idx_d   = '0;
					found_d = 1'b0;
					state_d = ST_REMOVE;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_REMOVE: begin
				// Past the match, move each entry down by one
				if (found_q) begin
					srt_we    = 1'b1;
					srt_waddr = idx_q - 1'b1;
					srt_wdata = srt_rdata;
				end
				found_d = found_q | cmp_eq;
				if (idx_q == AW'(present_q - 1'b1)) begin
					present_d = present_q - 1'b1;
					state_d   = ST_WRITE;
				end else begin
					idx_d     = idx_q + 1'b1;
					srt_raddr = idx_q + 1'b1;
				end
			end
			ST_WRITE: begin
				ring_we = 1'b1;
				fill_d  = fill_q + 1'b1;
				if (miss_q || (present_q == CW'(WINDOW_MAX))) begin
					state_d = ST_MEDRD;
				end else if (present_q == '0) begin
					srt_we    = 1'b1;
					present_d = present_q + 1'b1;
					state_d   = ST_MEDRD;
				end else begin
					idx_d     = AW'(present_q - 1'b1);
					srt_raddr = AW'(present_q - 1'b1);
					state_d   = ST_INSERT;
				end
			end
			ST_INSERT: begin
				// Walk down from the top; larger entries move up by one
				srt_we    = 1'b1;
				srt_waddr = idx_q + 1'b1;
				if (cmp_gt) begin
					srt_wdata = srt_rdata;
					if (idx_q == '0) begin
						state_d = ST_INSLAST;
					end else begin
						idx_d     = idx_q - 1'b1;
						srt_raddr = idx_q - 1'b1;
					end
				end else begin
					present_d = present_q + 1'b1;
					state_d   = ST_MEDRD;
				end
			end
			ST_INSLAST: begin
				srt_we    = 1'b1;
				present_d = present_q + 1'b1;
				state_d   = ST_MEDRD;
			end
			ST_MEDRD: begin
				if (!med_ok) begin
					med_d   = '0;
					ok_d    = 1'b0;
					state_d = ST_DONE;
				end else begin
					srt_raddr = present_q[0] ? half : half - 1'b1;
					state_d   = ST_MEDLO;
				end
			end
			ST_MEDLO: begin
				if (present_q[0]) begin
					med_d   = srt_rdata ^ SIGN_BIT;
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end else begin
					lo_d      = srt_rdata;
					srt_raddr = half;
					state_d   = ST_MEDHI;
				end
			end
			ST_MEDHI: begin
				diff_d  = srt_rdata - lo_q;
				state_d = ST_MEDSUM;
			end
			ST_MEDSUM: begin
				med_d   = (lo_q + (diff_q >> 1)) ^ SIGN_BIT;
				ok_d    = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cfg.clear) begin
			fill_d    = '0;
			oldest_d  = '0;
			present_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			oldest_q  <= '0;
			present_q <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			oldest_q  <= oldest_d;
			present_q <= present_d;
			idx_q     <= idx_d;
			found_q   <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= key_d;
		miss_q  <= miss_d;
		evkey_q <= evkey_d;
		lo_q    <= lo_d;
		diff_q  <= diff_d;
		med_q   <= med_d;
		ok_q    <= ok_d;
	end

endmodule

// ----- design/sliding_window_median_top.sv -----
// Top level of the sliding window median filter: configuration registers,
// stream ports and output register. Depends on swm_pkg and swm_ctrl.
//
// Each input word carries one signed Q16.16 sample with a missing flag and a
// start-of-slice flag; each yields one output word holding the median of the
// present samples among the last window_size words, the mean of the two middle
// values rounded down when their count is even, and a valid flag that drops
// (with the median forced to zero) when fewer than least_present values are
// present. A start-of-slice flag, or a write to window_size, empties the window
// first.
// Words are handled one at a time, each paced by the walk through the sorted value
// memory, whose single read and single write port the one comparator steps through
// one entry a cycle (once to drop the evicted value, once to place the new one),
// followed by the median read and average.
// s_tready is high only between words; a finished word waits in the output
// register, so the next input word is taken while it is still unclaimed.
// Both memories need no clearing after reset, as only written entries are read.
module sliding_window_median_top #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Input stream
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // sample
	input  logic [1:0]                               s_tuser,  // sample_missing, start_slice
	// Output stream
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // median
	output logic [0:0]                               m_tuser,  // median_valid
	// Configuration port
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [2:0]                               paddr,
	input  logic [31:0]                              pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	logic [swm_pkg::CFG_W-1:0] window_size_q, least_present_q;
	logic                      cfg_wr;
	swm_pkg::cfg_t             cfg;

	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           res_valid, res_ready, res_ok;
	logic [SAMPLE_WIDTH-1:0]        res_median;
	logic                           m_tvalid_q, median_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;

	// Register writes complete in the access phase; no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= swm_pkg::WINDOW_SIZE_RST;
			least_present_q <= swm_pkg::LEAST_PRESENT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				swm_pkg::REG_WINDOW_SIZE:   window_size_q   <= pwdata[swm_pkg::CFG_W-1:0];
				swm_pkg::REG_LEAST_PRESENT: least_present_q <= pwdata[swm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			swm_pkg::REG_WINDOW_SIZE:   prdata = 32'(window_size_q);
			swm_pkg::REG_LEAST_PRESENT: prdata = 32'(least_present_q);
			default:                    prdata = '0;
		endcase
	end

	// Writing window_size empties the window, as a slice start does
	assign cfg.window_size   = window_size_q;
	assign cfg.least_present = least_present_q;
	assign cfg.clear         = cfg_wr && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);

	assign sample = s_tdata[SAMPLE_WIDTH-1:0];

	swm_ctrl #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_sample  (sample),
		.in_missing (s_tuser[swm_pkg::TUSER_MISSING]),
		.in_start   (s_tuser[swm_pkg::TUSER_START]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_median (res_median),
		.res_ok     (res_ok)
	);

	// Output register: load when empty or being drained, hold otherwise
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			median_q       <= res_median;
			median_valid_q <= res_ok;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = TDATA_W'(unsigned'(median_q));
	assign m_tuser[0] = median_valid_q;

endmodule

// ----- design/swm_checker.sv -----
// Port-level checks for the sliding window median top level, and the bind
// that attaches them. Depends on sliding_window_median_top.
module swm_checker #(
	parameter int DW = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata,
	input logic [0:0]    m_tuser
);

	// The block is not ready again in the cycle after it accepts a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after an accept");

	// An invalid median carries zero
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("invalid median with nonzero data");

	// A new result appears only after the sequencer has left idle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the block was idle");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output word changed");

endmodule

bind sliding_window_median_top swm_checker #(.DW(TDATA_W)) u_swm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- tb/sliding_window_median_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_median_top: streams sample words, writes
// least_present and mostly window_size between phases, and checks every median word
// against a predictor. Depends on swm_pkg and the design files of the block.
module sliding_window_median_top_test;

	localparam int WINDOW_MAX    = 64;
	localparam int LIMIT_CYCLES  = 1_000_000;
	// Time to watch for stray words after the last drain
	localparam int SETTLE_CYCLES = 200;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		logic [31:0] median;
		logic        valid;
	} median_word_t;

	// Predictor of the filter plus the store of medians still to come out
	class median_scoreboard;
		int                          ring_value [WINDOW_MAX];
		bit                          ring_missing [WINDOW_MAX];
		int                          sorted_values [$];
		int unsigned                 fill_level;
		int unsigned                 oldest;
		logic [swm_pkg::CFG_W-1:0]   window_reg;
		logic [swm_pkg::CFG_W-1:0]   min_reg;
		median_word_t                expected_medians [$];
		int                          mismatches;
		int                          words_in;
		int                          medians_checked;
		int                          medians_valid;

		function new();
			window_reg      = swm_pkg::WINDOW_SIZE_RST;
			min_reg         = swm_pkg::LEAST_PRESENT_RST;
			fill_level      = 0;
			oldest          = 0;
			mismatches      = 0;
			words_in        = 0;
			medians_checked = 0;
			medians_valid   = 0;
		endfunction

		function void empty_window();
			fill_level = 0;
			oldest     = 0;
			sorted_values.delete();
		endfunction

		function void write_register(logic reg_sel, logic [31:0] value);
			if (reg_sel == swm_pkg::REG_WINDOW_SIZE) begin
				window_reg = value[swm_pkg::CFG_W-1:0];
				empty_window();
			end else begin
				min_reg = value[swm_pkg::CFG_W-1:0];
			end
		endfunction

		function int outstanding();
			return expected_medians.size();
		endfunction

		function void predict_median(logic [31:0] smp, bit miss, bit start);
			int unsigned  span;
			int unsigned  pos;
			int           need;
			int           half;
			int           idx;
			int           key;
			longint       pair_sum;
			median_word_t exp;

			words_in++;
			key  = smp;
			span = 32'(window_reg);
			if (span == 0)
				span = 1;
			if (span > WINDOW_MAX)
				span = WINDOW_MAX;
			if (start)
				empty_window();

			// Evict the oldest word once the window is full
			if (fill_level >= span) begin
				pos = oldest;
				if (!ring_missing[pos]) begin
					idx = -1;
					foreach (sorted_values[i])
						if (idx < 0 && sorted_values[i] == ring_value[pos])
							idx = i;
					if (idx >= 0)
						sorted_values.delete(idx);
				end
				oldest = (oldest + 1) % WINDOW_MAX;
				fill_level--;
			end
			pos               = (oldest + fill_level) % WINDOW_MAX;
			ring_value[pos]   = key;
			ring_missing[pos] = miss;
			fill_level++;
			if (!miss) begin
				idx = 0;
				while (idx < sorted_values.size() && sorted_values[idx] <= key)
					idx++;
				sorted_values.insert(idx, key);
			end

			need = (min_reg == 0) ? 1 : int'(min_reg);
			if (sorted_values.size() < need || sorted_values.size() == 0) begin
				exp.median = 32'd0;
				exp.valid  = 1'b0;
			end else begin
				half = sorted_values.size() / 2;
				if (sorted_values.size() % 2 == 1) begin
					exp.median = sorted_values[half];
				end else begin
					// Floor of the mean: arithmetic shift of the wide sum
					pair_sum   = longint'(sorted_values[half - 1]) + longint'(sorted_values[half]);
					exp.median = 32'(pair_sum >>> 1);
				end
				exp.valid = 1'b1;
			end
			expected_medians.push_back(exp);
		endfunction

		function void check_median(logic [31:0] got_median, logic got_valid);
			median_word_t exp;

			medians_checked++;
			if (got_valid === 1'b1)
				medians_valid++;
			if (expected_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected median word: median %h valid %b", got_median, got_valid);
				return;
			end
			exp = expected_medians.pop_front();
			if (got_median !== exp.median || got_valid !== exp.valid) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("median word %0d: expected median %h valid %b, got median %h valid %b",
						medians_checked, exp.median, exp.valid, got_median, got_valid);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = 32'd0;
	logic [1:0]  s_tuser  = 2'b00;  // sample_missing, start_slice
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // median
	logic [0:0]  m_tuser;           // median_valid
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	median_scoreboard board = new();
	bit               gaps_on = 1'b1;  // random idling on both sides
	int               cycle_count = 0;
	int               settings_used = 1;

	sliding_window_median_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d medians outstanding",
				cycle_count, board.outstanding());
			$display("sliding_window_median_top: mismatch");
			$finish;
		end
	end

	// Receiver: stall at random, change only at the falling edge
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !(gaps_on && $urandom_range(0, 99) < 16);
	end

	// Check every median word at the edge that moves it
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_median(m_tdata, m_tuser[0]);
	end

	// Offer one sample word and hold it until taken; valid stays high afterwards
	// so that back-to-back words need no second assignment in one step.
	task automatic send_word(input logic [31:0] smp, input bit miss, input bit start);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 16) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid                         = 1'b1;
		s_tdata                          = smp;
		s_tuser[swm_pkg::TUSER_MISSING]  = miss;
		s_tuser[swm_pkg::TUSER_START]    = start;
		do
			@(posedge clk);
		while (!s_tready);
		board.predict_median(smp, miss, start);
	endtask

	// Drop valid and wait until every median word has come out
	task automatic drain_words();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge
	task automatic write_register(input logic reg_sel, input logic [6:0] field);
		logic [31:0] value;

		// Fill the unused upper bits with noise; the block must ignore them
		value = ($urandom() & ~32'h7F) | {25'd0, field};
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_sel, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		board.write_register(reg_sel, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Mix of extremes, near-extremes, small clustered values and full-range noise
	function automatic logic [31:0] random_sample();
		int offset;

		offset = $urandom_range(0, 16);
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
			3:       return 32'h8000_0000 + $urandom_range(0, 3);
			4, 5:    return 32'((offset - 8) * 65536);
			default: return $urandom();
		endcase
	endfunction

	// One setting of the registers followed by random words. Missing words come
	// singly or in bursts, so that windows of only missing samples occur too.
	task automatic run_phase(input bit set_window, input logic [6:0] window,
			input logic [6:0] min_present, input int words, input int miss_pct,
			input int start_pct, input bit quiet);
		int burst;
		bit miss;

		burst = 0;
		drain_words();
		if (set_window)
			write_register(swm_pkg::REG_WINDOW_SIZE, window);
		write_register(swm_pkg::REG_LEAST_PRESENT, min_present);
		settings_used++;
		gaps_on = !quiet;
		repeat (words) begin
			if (burst == 0 && $urandom_range(0, 99) < 2)
				burst = $urandom_range(1, 70);
			miss = (burst > 0) || ($urandom_range(0, 99) < miss_pct);
			if (burst > 0)
				burst--;
			send_word(random_sample(), miss, $urandom_range(0, 99) < start_pct);
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		// Hold reset, release at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset setting (window 5, min count 1)
		send_word(32'h7FFF_FFFF, 1'b0, 1'b1);  // slice start on an empty window
		send_word(32'h8000_0000, 1'b0, 1'b0);  // mean of the two extremes
		send_word(32'hFFFF_FFFF, 1'b1, 1'b0);  // missing, value ignored
		send_word(32'h0000_0000, 1'b0, 1'b0);
		send_word(32'h0001_0000, 1'b0, 1'b0);
		send_word(32'hFFFF_0000, 1'b0, 1'b0);  // evicts the maximum
		send_word(32'h8000_0000, 1'b1, 1'b0);  // missing extreme, ignored
		send_word(32'h8000_0000, 1'b0, 1'b0);
		send_word(32'h1234_5678, 1'b1, 1'b1);  // slice start with a missing word: invalid
		send_word(32'h7FFF_FFFF, 1'b1, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0, 1'b0);  // equal values
		send_word(32'h7FFF_FFFE, 1'b0, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
		send_word(32'h8000_0001, 1'b0, 1'b0);
		send_word(32'h8000_0000, 1'b0, 1'b0);
		repeat (5)
			send_word(32'h5555_AAAA, 1'b1, 1'b0);  // window of only missing words
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);      // minus one LSB
		send_word(32'h0000_0001, 1'b0, 1'b0);
		send_word(32'hFFFF_FFFE, 1'b0, 1'b1);

		// Random phases, extremes of both registers among them
		run_phase(1'b1, 7'd1,   7'd1,  60,  15, 3, 1'b0);
		run_phase(1'b1, 7'd64,  7'd1,  300, 10, 1, 1'b1);  // no idling in this phase
		run_phase(1'b1, 7'd0,   7'd0,  40,  20, 3, 1'b0);  // zero read as one
		run_phase(1'b1, 7'd127, 7'd70, 150, 10, 2, 1'b0);  // window saturates, never valid
		run_phase(1'b1, 7'd64,  7'd64, 200, 3,  1, 1'b0);
		run_phase(1'b0, 7'd64,  7'd127, 40, 5,  0, 1'b0);  // min count only, window kept
		run_phase(1'b1, 7'd7,   7'd3,  200, 30, 3, 1'b0);
		run_phase(1'b0, 7'd7,   7'd1,  60,  30, 3, 1'b0);
		run_phase(1'b1, 7'd2,   7'd2,  120, 40, 4, 1'b0);
		run_phase(1'b1, 7'd33,  7'd10, 220, 15, 1, 1'b0);
		run_phase(1'b1, 7'd100, 7'd1,  150, 10, 1, 1'b0);
		run_phase(1'b1, 7'd4,   7'd5,  80,  10, 3, 1'b0);  // min count above window

		drain_words();
		// Watch a while longer for stray words
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d sample words over %0d register settings, window sizes 0 to 127",
			board.words_in, settings_used);
		$display("%0d median words checked, %0d of them valid, %0d mismatches",
			board.medians_checked, board.medians_valid, board.mismatches);
		if (board.mismatches == 0)
			$display("sliding_window_median_top: match");
		else
			$display("sliding_window_median_top: mismatch");
		$finish;
	end

endmodule
